>>> design/cwg_pkg.sv
// Shared widths, wheel constants and types for the colour wheel gradient generator.
// No dependencies; used by every module under design/.
package cwg_pkg;

    localparam int CWG_POS_W       = 10;
    localparam int CWG_CH_W        = 8;
    localparam int CWG_CNT_W       = 7;
    localparam int CWG_MAX_STEPS   = 64;

    // wheel thirds
    localparam logic [CWG_POS_W-1:0] CWG_THIRD_1   = 10'd341;
    localparam logic [CWG_POS_W-1:0] CWG_THIRD_2   = 10'd682;
    localparam logic [CWG_POS_W-1:0] CWG_THIRD_2P1 = 10'd683;
    localparam logic [CWG_CH_W-1:0]  CWG_CH_MAX    = 8'd255;

    // floor(y/3) == (y * CWG_RECIP3) >> CWG_RECIP3_SH, exact for y < 1536
    localparam logic [CWG_POS_W:0]   CWG_RECIP3    = 11'd683;
    localparam int                   CWG_RECIP3_SH = 11;

    // payload widths
    localparam int CWG_IN_TDATA_W  = 80;
    localparam int CWG_OUT_TDATA_W = 40;

    typedef logic [CWG_POS_W-1:0] pos_t;
    typedef logic [CWG_CH_W-1:0]  chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

endpackage

>>> design/cwg_endpoint.sv
// RGB colour to wheel position (inverse map), one endpoint.
// Depends on cwg_pkg.
module cwg_endpoint (
    input  cwg_pkg::rgb_t color,
    output cwg_pkg::pos_t position
);
    import cwg_pkg::*;

    chan_t                   sel;
    logic [CWG_POS_W-1:0]    scaled;   // sel * 4
    logic [2*CWG_POS_W-1:0]  prod;
    logic [CWG_POS_W-2:0]    third;    // scaled / 3, at most 340

    always_comb
    begin
        if (color.red == '0)
            sel = color.blue;
        else if (color.green == '0)
            sel = color.red;
        else
            sel = color.green;
    end

    assign scaled = {sel, 2'b00};
    assign prod   = 20'(scaled) * 20'(CWG_RECIP3);
    assign third  = prod[CWG_RECIP3_SH +: CWG_POS_W-1];

    always_comb
    begin
        if (color.red == '0)
            position = pos_t'(third) + CWG_THIRD_1;
        else if (color.green == '0)
            position = pos_t'(third) + CWG_THIRD_2P1;
        else if (color.blue == '0)
            position = pos_t'(third);
        else
            position = '0;
    end

endmodule

>>> design/cwg_map.sv
// Wheel position to RGB colour (forward map by thirds, 3/4 scaling).
// Depends on cwg_pkg.
module cwg_map (
    input  cwg_pkg::pos_t position,
    output cwg_pkg::rgb_t color
);
    import cwg_pkg::*;

    pos_t              offset;
    logic [CWG_POS_W+1:0] tripled;
    chan_t             v;

    always_comb
    begin
        if (position < CWG_THIRD_1)
            offset = position;
        else if (position < CWG_THIRD_2)
            offset = position - CWG_THIRD_1;
        else if (position == CWG_THIRD_2)
            offset = '0;  // just below the last third: truncates to zero
        else
            offset = position - CWG_THIRD_2P1;
    end

    // offset <= 340, so offset*3/4 fits a channel
    assign tripled = {1'b0, offset, 1'b0} + {2'b00, offset};
    assign v       = tripled[CWG_CH_W+1:2];

    always_comb
    begin
        if (position < CWG_THIRD_1)
        begin
            color.red   = CWG_CH_MAX - v;
            color.green = v;
            color.blue  = '0;
        end
        else if (position < CWG_THIRD_2)
        begin
            color.red   = '0;
            color.green = CWG_CH_MAX - v;
            color.blue  = v;
        end
        else
        begin
            color.red   = v;
            color.green = '0;
            color.blue  = CWG_CH_MAX - v;
        end
    end

endmodule

>>> design/cwg_div.sv
// Restoring divider, one quotient bit per cycle, for the step increment setup.
// Depends on cwg_pkg.
module cwg_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [cwg_pkg::CWG_POS_W:0]   dividend,
    input  logic [cwg_pkg::CWG_CNT_W-1:0] divisor,
    output logic [cwg_pkg::CWG_POS_W:0]   quotient,
    output logic [cwg_pkg::CWG_CNT_W-1:0] remainder,
    output logic                     done
);
    import cwg_pkg::*;

    localparam int QW = CWG_POS_W + 1;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0]        quo_reg, quo_next;
    logic [CWG_CNT_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [CWG_CNT_W:0]   shifted;

    assign shifted = {rem_reg, quo_reg[QW-1]};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CW'(QW);
        end
        else if (cnt_reg != '0)
        begin
            if (shifted >= {1'b0, divisor})
            begin
                rem_next = CWG_CNT_W'(shifted - {1'b0, divisor});
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[CWG_CNT_W-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

>>> design/color_wheel_gradient_generator.sv
// Top level of the colour wheel gradient generator: request intake, sequencer, output register.
// Depends on cwg_pkg, cwg_endpoint, cwg_map, cwg_div.
//
// Usage:
//   Slave channel (s_*) takes one request: two endpoints and a step count n.
//   s_tuser selects how the endpoints are read: 0 = wheel positions,
//   1 = RGB colours, which are first inverted to wheel positions.
//   Master channel (m_*) returns n colours evenly spaced from start to end,
//   each with its wheel position; m_tlast marks the final colour.
//   n = 0 acts as 1 (start only); n above MAX_STEPS is cut to MAX_STEPS.
// Timing:
//   Accept -> setup state -> serial restoring divide of 2*|end-start|
//   by 2*(n-1) -> n results, one per cycle while m_tready is high.
//   Results leave through the single output register.
//   s_tready is high only while no request is in flight; the next request
//   may be accepted while the final result still waits in the output register.
// Reset: asynchronous, active low; clears the sequencer and m_tvalid.
// Stall: a low m_tready holds a valid output register and freezes stepping.
module color_wheel_gradient_generator #(
    parameter int MAX_STEPS = cwg_pkg::CWG_MAX_STEPS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [9:0] start_position, [19:10] end_position, [27:20] start_red,
    // [35:28] start_green, [43:36] start_blue, [51:44] end_red,
    // [59:52] end_green, [67:60] end_blue, [74:68] step_count, rest zero
    input  logic [cwg_pkg::CWG_IN_TDATA_W-1:0]    s_tdata,
    // [0] action
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [33:24] position, rest zero
    output logic [cwg_pkg::CWG_OUT_TDATA_W-1:0]   m_tdata,
    output logic                                  m_tlast
);
    import cwg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    typedef logic [CWG_CNT_W-1:0] cnt_t;

    state_t state_reg, state_next;

    // request field unpack
    pos_t  in_start_pos, in_end_pos;
    rgb_t  in_start_rgb, in_end_rgb;
    cnt_t  in_steps;
    pos_t  start_from_rgb, end_from_rgb;

    assign in_start_pos       = s_tdata[9:0];
    assign in_end_pos         = s_tdata[19:10];
    assign in_start_rgb.red   = s_tdata[27:20];
    assign in_start_rgb.green = s_tdata[35:28];
    assign in_start_rgb.blue  = s_tdata[43:36];
    assign in_end_rgb.red     = s_tdata[51:44];
    assign in_end_rgb.green   = s_tdata[59:52];
    assign in_end_rgb.blue    = s_tdata[67:60];
    assign in_steps           = s_tdata[74:68];

    cwg_endpoint u_start_ep (
        .color    (in_start_rgb),
        .position (start_from_rgb)
    );

    cwg_endpoint u_end_ep (
        .color    (in_end_rgb),
        .position (end_from_rgb)
    );

    logic accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // request registers
    pos_t start_reg, start_next;
    pos_t end_reg, end_next;
    cnt_t n_reg, n_next;

    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        n_next     = n_reg;
        if (accept)
        begin
            start_next = s_tuser ? start_from_rgb : in_start_pos;
            end_next   = s_tuser ? end_from_rgb   : in_end_pos;
            if (in_steps == '0)
                n_next = cnt_t'(1);
            else if (in_steps > cnt_t'(MAX_STEPS))
                n_next = cnt_t'(MAX_STEPS);
            else
                n_next = in_steps;
        end
    end

    // increment setup: 2*mag = A*D + B with D = 2*(n-1), or 2 when n is 1
    logic                 down;
    pos_t                 mag;
    logic [CWG_CNT_W-2:0] den;
    cnt_t                 two_den;
    logic                 div_done;
    logic [CWG_POS_W:0]   div_quo;
    cnt_t                 div_rem;

    assign down    = end_reg < start_reg;
    assign mag     = down ? (start_reg - end_reg) : (end_reg - start_reg);
    assign den     = (n_reg > cnt_t'(1)) ? (CWG_CNT_W-1)'(n_reg - 1'b1)
                                         : (CWG_CNT_W-1)'(1);
    assign two_den = {den, 1'b0};

    cwg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == ST_SETUP),
        .dividend  ({mag, 1'b0}),
        .divisor   (two_den),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // stepping accumulator: q_k = (2*mag*k + den) / (2*den), carried as q, rem
    pos_t inc_whole_reg, inc_whole_next;
    cnt_t inc_frac_reg, inc_frac_next;
    pos_t q_reg, q_next;
    cnt_t rem_reg, rem_next;
    cnt_t k_reg, k_next;
    logic [CWG_CNT_W:0] rem_sum;

    assign rem_sum = {1'b0, rem_reg} + {1'b0, inc_frac_reg};

    // output register
    logic  out_load;
    logic  is_last;
    pos_t  cur_pos;
    rgb_t  cur_rgb;
    logic  m_tvalid_reg, m_tvalid_next;
    logic  m_tlast_reg, m_tlast_next;
    rgb_t  rgb_reg, rgb_next;
    pos_t  pos_reg, pos_next;

    assign cur_pos  = down ? (start_reg - q_reg) : (start_reg + q_reg);
    assign is_last  = (k_reg == n_reg - 1'b1);
    assign out_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    cwg_map u_map (
        .position (cur_pos),
        .color    (cur_rgb)
    );

    always_comb
    begin
        state_next     = state_reg;
        inc_whole_next = inc_whole_reg;
        inc_frac_next  = inc_frac_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        k_next         = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    inc_whole_next = div_quo[CWG_POS_W-1:0];
                    inc_frac_next  = div_rem;
                    q_next         = '0;
                    rem_next       = cnt_t'(den);
                    k_next         = '0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    k_next = k_reg + 1'b1;
                    if (rem_sum >= {1'b0, two_den})
                    begin
                        rem_next = cnt_t'(rem_sum - {1'b0, two_den});
                        q_next   = q_reg + inc_whole_reg + 1'b1;
                    end
                    else
                    begin
                        rem_next = rem_sum[CWG_CNT_W-1:0];
                        q_next   = q_reg + inc_whole_reg;
                    end
                    if (is_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tlast_next  = m_tlast_reg;
        rgb_next      = rgb_reg;
        pos_next      = pos_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tlast_next  = is_last;
            rgb_next      = cur_rgb;
            pos_next      = cur_pos;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg     <= start_next;
        end_reg       <= end_next;
        n_reg         <= n_next;
        inc_whole_reg <= inc_whole_next;
        inc_frac_reg  <= inc_frac_next;
        q_reg         <= q_next;
        rem_reg       <= rem_next;
        k_reg         <= k_next;
        m_tlast_reg   <= m_tlast_next;
        rgb_reg       <= rgb_next;
        pos_reg       <= pos_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {6'b0, pos_reg, rgb_reg.blue, rgb_reg.green, rgb_reg.red};

`ifndef SYNTHESIS
    // an accepted request always goes to setup next
    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SETUP))
        else $error("accepted request did not enter setup");

    // the divider only finishes while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    // step index never runs past the step count
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (k_reg < n_reg))
        else $error("step index beyond step count");

    // the final result of a run returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && is_last) |=> (state_reg == ST_IDLE) && m_tlast_reg)
        else $error("final result did not end the run");
`endif

endmodule

>>> test/color_wheel_gradient_generator_test.sv
// Self-checking testbench for color_wheel_gradient_generator: directed table, then random requests.
// Depends on cwg_pkg and the design under design/; color runs are predicted in SV and compared.
`timescale 1ns / 1ps

module color_wheel_gradient_generator_test;
    import cwg_pkg::*;

    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_REQUESTS = 246;
    localparam int LONG_HOLD = 300;    // receiver hold-off, in cycles
    localparam int HOLD_AFTER = 40;    // requests accepted before the hold-off starts
    localparam int IDLE_LIMIT = 2000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 30;  // cycles run on after the last expected color

    localparam rgb_t BLACK = '0;

    // one request as the block sees it
    typedef struct {
        logic                 action;  // 0 positions, 1 RGB endpoints
        pos_t                 start_pos;
        pos_t                 end_pos;
        rgb_t                 start_rgb;
        rgb_t                 end_rgb;
        logic [CWG_CNT_W-1:0] steps;
    } gradient_req_t;

    // directed row: typed rows carry a single hand-read color (step count 0 or 1)
    typedef struct {
        gradient_req_t req;
        bit            typed;
        rgb_t          want_rgb;
        pos_t          want_pos;
    } gradient_row_t;

    // one color of a run
    typedef struct {
        chan_t red;
        chan_t green;
        chan_t blue;
        pos_t  position;
        logic  last;
    } shade_t;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [CWG_IN_TDATA_W-1:0]  s_tdata = '0;
    logic                       s_tuser = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [CWG_OUT_TDATA_W-1:0] m_tdata;
    logic                       m_tlast;

    shade_t        expected_shades[$];
    gradient_row_t directed_rows[DIRECTED_ROWS];

    int  error_count = 0;
    int  requests_accepted = 0;
    int  color_requests = 0;
    int  colors_checked = 0;
    int  idle_cycles = 0;
    bit  long_hold_done = 1'b0;

    color_wheel_gradient_generator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // RGB endpoint -> wheel position; first zero channel picks the third
    function automatic int color_to_wheel(rgb_t c);
        if (c.red == 0)
            return (int'(c.blue) * 4) / 3 + int'(CWG_THIRD_1);
        if (c.green == 0)
            return (int'(c.red) * 4) / 3 + int'(CWG_THIRD_2P1);
        if (c.blue == 0)
            return (int'(c.green) * 4) / 3;
        return 0;
    endfunction

    // wheel position -> RGB, each third scaled by 3/4, truncating
    function automatic rgb_t wheel_to_color(int p);
        rgb_t c;
        int   v;
        if (p < int'(CWG_THIRD_1))
        begin
            v = (p * 3) / 4;
            c = {8'(255 - v), 8'(v), 8'd0};
        end
        else if (p < int'(CWG_THIRD_2))
        begin
            v = ((p - int'(CWG_THIRD_1)) * 3) / 4;
            c = {8'd0, 8'(255 - v), 8'(v)};
        end
        else
        begin
            // 682 sits just below the last third; its offset counts as zero
            v = (p >= int'(CWG_THIRD_2P1)) ? ((p - int'(CWG_THIRD_2P1)) * 3) / 4 : 0;
            if (v > 255)
                v = 255;
            c = {8'(v), 8'd0, 8'(255 - v)};
        end
        return c;
    endfunction

    // queue every color a request must produce
    function automatic void predict_gradient(gradient_req_t req);
        int     s, e, n, mag, den, q, p, k;
        bit     down;
        rgb_t   c;
        shade_t sh;
        if (!req.action)
        begin
            s = int'(req.start_pos);
            e = int'(req.end_pos);
        end
        else
        begin
            s = color_to_wheel(req.start_rgb);
            e = color_to_wheel(req.end_rgb);
        end
        if (s > 1023) s = 1023;
        if (e > 1023) e = 1023;
        n = int'(req.steps);
        if (n == 0) n = 1;
        if (n > CWG_MAX_STEPS) n = CWG_MAX_STEPS;
        down = e < s;
        mag = down ? s - e : e - s;
        den = (n > 1) ? n - 1 : 1;
        for (k = 0; k < n; k++)
        begin
            // exact rational step, rounded half away from zero
            q = (2 * mag * k + den) / (2 * den);
            p = (n > 1) ? (down ? s - q : s + q) : s;
            c = wheel_to_color(p);
            sh.red = c.red;
            sh.green = c.green;
            sh.blue = c.blue;
            sh.position = pos_t'(p);
            sh.last = (k + 1 == n);
            expected_shades.push_back(sh);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic gradient_row_t make_row(logic act, int sp, int ep, rgb_t sc, rgb_t ec,
                                               int steps, bit typed, rgb_t want_rgb,
                                               int want_pos);
        gradient_row_t r;
        r.req.action = act;
        r.req.start_pos = pos_t'(sp);
        r.req.end_pos = pos_t'(ep);
        r.req.start_rgb = sc;
        r.req.end_rgb = ec;
        r.req.steps = CWG_CNT_W'(steps);
        r.typed = typed;
        r.want_rgb = want_rgb;
        r.want_pos = pos_t'(want_pos);
        return r;
    endfunction

    // boundary positions come up often; the rest is uniform
    function automatic pos_t random_position();
        if ($urandom_range(0, 3) != 0)
            return pos_t'($urandom_range(0, 1023));
        case ($urandom_range(0, 8))
            0: return 10'd0;
            1: return 10'd340;
            2: return 10'd341;
            3: return 10'd342;
            4: return 10'd681;
            5: return 10'd682;
            6: return 10'd683;
            7: return 10'd1022;
            default: return 10'd1023;
        endcase
    endfunction

    // a zeroed channel steers the inversion; mode 3 mostly falls through to zero
    function automatic rgb_t random_color();
        rgb_t c;
        c.red = chan_t'($urandom_range(0, 255));
        c.green = chan_t'($urandom_range(0, 255));
        c.blue = chan_t'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: c.red = '0;
            1: c.green = '0;
            2: c.blue = '0;
            default: ;
        endcase
        return c;
    endfunction

    // mostly short runs, some long ones, zero and oversized counts now and then
    function automatic logic [CWG_CNT_W-1:0] random_steps();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return CWG_CNT_W'($urandom_range(1, 8));
        if (pick < 17)
            return CWG_CNT_W'($urandom_range(9, 64));
        if (pick == 17)
            return '0;
        return CWG_CNT_W'($urandom_range(0, 127));
    endfunction

    function automatic gradient_req_t random_request();
        gradient_req_t req;
        // unused endpoint fields are random too, so every input bit toggles
        req.action = 1'($urandom_range(0, 1));
        req.start_pos = random_position();
        req.end_pos = random_position();
        req.start_rgb = random_color();
        req.end_rgb = random_color();
        req.steps = random_steps();
        return req;
    endfunction

    // offer one request and hold it until accepted; expectations queued at accept
    task automatic send_request(input gradient_req_t req, input bit typed, input shade_t want);
        s_tdata <= {5'b0, req.steps,
                    req.end_rgb.blue, req.end_rgb.green, req.end_rgb.red,
                    req.start_rgb.blue, req.start_rgb.green, req.start_rgb.red,
                    req.end_pos, req.start_pos};
        s_tuser <= req.action;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_accepted++;
        if (req.action)
            color_requests++;
        if (typed)
            expected_shades.push_back(want);
        else
            predict_gradient(req);
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random bursts, drain
    // ------------------------------------------------------------------
    initial
    begin
        gradient_req_t req;
        shade_t        want;
        int            i;
        int            gap;
        int            burst_left;

        // single-color rows read straight off the wheel
        directed_rows[0]  = make_row(1'b0, 0, 0, BLACK, BLACK, 1, 1'b1,
                                     {8'd255, 8'd0, 8'd0}, 0);
        directed_rows[1]  = make_row(1'b0, 340, 0, BLACK, BLACK, 1, 1'b1,
                                     {8'd0, 8'd255, 8'd0}, 340);
        directed_rows[2]  = make_row(1'b0, 341, 0, BLACK, BLACK, 1, 1'b1,
                                     {8'd0, 8'd255, 8'd0}, 341);
        // 682: offset below the last third truncates to zero
        directed_rows[3]  = make_row(1'b0, 682, 0, BLACK, BLACK, 1, 1'b1,
                                     {8'd0, 8'd0, 8'd255}, 682);
        directed_rows[4]  = make_row(1'b0, 683, 0, BLACK, BLACK, 1, 1'b1,
                                     {8'd0, 8'd0, 8'd255}, 683);
        directed_rows[5]  = make_row(1'b0, 1023, 0, BLACK, BLACK, 1, 1'b1,
                                     {8'd255, 8'd0, 8'd0}, 1023);
        // step count zero behaves as one
        directed_rows[6]  = make_row(1'b0, 100, 900, BLACK, BLACK, 0, 1'b1,
                                     {8'd180, 8'd75, 8'd0}, 100);
        // color inversion, one row per rule, plus all channels zero
        directed_rows[7]  = make_row(1'b1, 0, 0, {8'd0, 8'd10, 8'd255}, BLACK, 1, 1'b1,
                                     {8'd0, 8'd0, 8'd255}, 681);
        directed_rows[8]  = make_row(1'b1, 0, 0, {8'd255, 8'd0, 8'd7}, BLACK, 1, 1'b1,
                                     {8'd255, 8'd0, 8'd0}, 1023);
        directed_rows[9]  = make_row(1'b1, 0, 0, {8'd12, 8'd255, 8'd0}, BLACK, 1, 1'b1,
                                     {8'd0, 8'd255, 8'd0}, 340);
        directed_rows[10] = make_row(1'b1, 0, 0, {8'd1, 8'd1, 8'd1}, BLACK, 0, 1'b1,
                                     {8'd255, 8'd0, 8'd0}, 0);
        directed_rows[11] = make_row(1'b1, 0, 0, BLACK, BLACK, 1, 1'b1,
                                     {8'd0, 8'd255, 8'd0}, 341);
        // full sweeps, up and down, at and beyond the step limit
        directed_rows[12] = make_row(1'b0, 0, 1023, BLACK, BLACK, 64, 1'b0, BLACK, 0);
        directed_rows[13] = make_row(1'b0, 1023, 0, BLACK, BLACK, 64, 1'b0, BLACK, 0);
        directed_rows[14] = make_row(1'b0, 0, 1023, BLACK, BLACK, 65, 1'b0, BLACK, 0);
        directed_rows[15] = make_row(1'b0, 1023, 0, BLACK, BLACK, 127, 1'b0, BLACK, 0);
        // half-step rounding both ways
        directed_rows[16] = make_row(1'b0, 10, 13, BLACK, BLACK, 7, 1'b0, BLACK, 0);
        directed_rows[17] = make_row(1'b0, 13, 10, BLACK, BLACK, 7, 1'b0, BLACK, 0);
        directed_rows[18] = make_row(1'b0, 500, 500, BLACK, BLACK, 5, 1'b0, BLACK, 0);
        directed_rows[19] = make_row(1'b0, 0, 1, BLACK, BLACK, 2, 1'b0, BLACK, 0);
        // colors in, across thirds
        directed_rows[20] = make_row(1'b1, 0, 0, {8'd0, 8'd0, 8'd255},
                                     {8'd255, 8'd255, 8'd0}, 16, 1'b0, BLACK, 0);
        directed_rows[21] = make_row(1'b1, 0, 0, {8'd255, 8'd0, 8'd255},
                                     {8'd128, 8'd0, 8'd0}, 10, 1'b0, BLACK, 0);
        // unused fields all ones must be ignored
        directed_rows[22] = make_row(1'b0, 1023, 0, {8'd255, 8'd255, 8'd255},
                                     {8'd255, 8'd255, 8'd255}, 3, 1'b0, BLACK, 0);
        directed_rows[23] = make_row(1'b1, 1023, 1023, {8'd255, 8'd255, 8'd255},
                                     {8'd0, 8'd255, 8'd255}, 33, 1'b0, BLACK, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            want.red = directed_rows[i].want_rgb.red;
            want.green = directed_rows[i].want_rgb.green;
            want.blue = directed_rows[i].want_rgb.blue;
            want.position = directed_rows[i].want_pos;
            want.last = 1'b1;
            send_request(directed_rows[i].req, directed_rows[i].typed, want);
        end

        // random part: bursts of back-to-back requests with idle gaps between
        burst_left = 0;
        for (i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 10);
            end
            req = random_request();
            send_request(req, 1'b0, want);
            burst_left--;
        end
        s_tvalid <= 1'b0;

        while (expected_shades.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests (%0d with color endpoints), %0d colors checked,",
                 requests_accepted, color_requests, colors_checked);
        $display("including a %0d-cycle receiver hold-off with the sender still offering.",
                 LONG_HOLD);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall patterns, plus one long hold-off mid-run
    // ------------------------------------------------------------------
    initial
    begin
        int mode;
        int span;
        @(posedge rst_n);
        forever
        begin
            if (!long_hold_done && requests_accepted >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                @(posedge clk);
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 40);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: each accepted color against the oldest expectation
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input logic [9:0] want,
                               input logic [9:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        shade_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            colors_checked++;
            if (expected_shades.size() == 0)
            begin
                error_count++;
                $display("%0t: color with no request pending, expected none,", $time,
                         " got tdata=%h tlast=%b", m_tdata, m_tlast);
            end
            else
            begin
                want = expected_shades.pop_front();
                check_field("red", 10'(want.red), 10'(m_tdata[7:0]));
                check_field("green", 10'(want.green), 10'(m_tdata[15:8]));
                check_field("blue", 10'(want.blue), 10'(m_tdata[23:16]));
                check_field("position", want.position, m_tdata[33:24]);
                check_field("last", 10'(want.last), 10'(m_tlast));
            end
        end
    end

    // watchdog: too long without any handshake ends the run
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

endmodule

>>> files.f
design/cwg_pkg.sv
design/cwg_endpoint.sv
design/cwg_map.sv
design/cwg_div.sv
design/color_wheel_gradient_generator.sv
test/color_wheel_gradient_generator_test.sv
